@@ design/dwrp_pkg.sv @@
// Shared types and constants for the draw-without-replacement pool.
package dwrp_pkg;

    localparam int PoolSize = 90;
    localparam int EntryW = 7;
    localparam int AddrW = 7;

    localparam logic [7:0] EmptyMark = 8'd255;

    typedef enum logic [1:0] {
        CMD_PICK  = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_UNDO  = 2'd2,
        CMD_RESET = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DRAWN = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_PICK_RD,
        S_PICK_WAIT,
        S_PICK_LAST,
        S_PICK_WR,
        S_SEARCH,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_UNDO_RD,
        S_UNDO_WR,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic           load_item;   // capture the input beat
        logic           mul_idx;     // compute pick index
        logic           pool_rd;     // read pool at addr
        logic           stack_rd;    // read stack at addr
        logic           pool_wr;
        logic           stack_wr;
        logic [1:0]     wsel;        // 0 fill value, 1 pool read, 2 stack read, 3 number
        logic [AddrW-1:0] addr;
        logic           hold_pick;   // latch pool read as picked number
        logic           cnt_pick;
        logic           cnt_add;
        logic           cnt_undo;
        logic           cnt_reset;
        logic           set_found;
        logic           clr_found;
        logic           res_load;
        logic [1:0]     res_kind;    // status code to report
        logic           res_drawn;   // report the picked number
    } cmd_bus_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cmd_t             cmd;
        logic [7:0]       number;
        logic [AddrW-1:0] pick_idx;
        logic [AddrW-1:0] pool_count;
        logic [AddrW-1:0] stack_count;
        logic [EntryW-1:0] pool_q;
        logic [EntryW-1:0] stack_q;
        logic             found;
    } stat_bus_t;

endpackage

@@ design/dwrp_datapath.sv @@
// Datapath: pool and stack memories, counters, index multiplier, result register.
module dwrp_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [41:0]         item,
    input  dwrp_pkg::cmd_bus_t  c,
    output dwrp_pkg::stat_bus_t st,
    output logic [23:0]         result
);
    import dwrp_pkg::*;

    logic [EntryW-1:0] pool_mem [PoolSize];
    logic [EntryW-1:0] stack_mem [PoolSize];
    logic [EntryW-1:0] pool_q_reg, stack_q_reg, pick_reg;
    logic [1:0]        cmd_reg;
    logic [7:0]        num_reg;
    logic [31:0]       rnd_reg;
    logic [AddrW-1:0]  idx_reg;
    logic [AddrW-1:0]  pcnt_reg, scnt_reg;
    logic              found_reg;
    logic [23:0]       result_reg;
    logic [EntryW-1:0] wdata;
    logic [38:0]       prod;

    assign prod = rnd_reg * pcnt_reg;

    always_comb begin
        case (c.wsel)
            2'd0: wdata = c.addr + 1'b1;
            2'd1: wdata = pool_q_reg;
            2'd2: wdata = stack_q_reg;
            default: wdata = num_reg[EntryW-1:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (c.pool_wr) pool_mem[c.addr] <= wdata;
        if (c.stack_wr) stack_mem[c.addr] <= wdata;
        if (c.pool_rd) pool_q_reg <= pool_mem[c.addr];
        if (c.stack_rd) stack_q_reg <= stack_mem[c.addr];
    end

    always_ff @(posedge aclk) begin
        if (c.load_item) begin
            cmd_reg <= item[1:0];
            num_reg <= item[9:2];
            rnd_reg <= item[41:10];
        end
        if (c.mul_idx) idx_reg <= prod[38:32];
        if (c.hold_pick) pick_reg <= pool_q_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcnt_reg <= AddrW'(PoolSize);
            scnt_reg <= '0;
            found_reg <= 1'b0;
            result_reg <= '0;
        end else begin
            if (c.cnt_reset) begin
                pcnt_reg <= AddrW'(PoolSize);
                scnt_reg <= '0;
            end else if (c.cnt_pick || c.cnt_add) begin
                pcnt_reg <= pcnt_reg - 1'b1;
                scnt_reg <= scnt_reg + 1'b1;
            end else if (c.cnt_undo) begin
                pcnt_reg <= pcnt_reg + 1'b1;
                scnt_reg <= scnt_reg - 1'b1;
            end
            if (c.clr_found) found_reg <= 1'b0;
            else if (c.set_found) found_reg <= 1'b1;
            if (c.res_load) begin
                result_reg <= {scnt_reg, pcnt_reg, c.res_kind,
                               c.res_drawn ? {1'b0, pick_reg} :
                               (c.res_kind == ST_EMPTY ? EmptyMark : 8'd0)};
            end
        end
    end

    assign st.cmd = cmd_t'(cmd_reg);
    assign st.number = num_reg;
    assign st.pick_idx = idx_reg;
    assign st.pool_count = pcnt_reg;
    assign st.stack_count = scnt_reg;
    assign st.pool_q = pool_q_reg;
    assign st.stack_q = stack_q_reg;
    assign st.found = found_reg;
    assign result = result_reg;

endmodule

@@ design/dwrp_ctrl.sv @@
// Controller state machine sequencing memory sweeps for each command.
module dwrp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  dwrp_pkg::stat_bus_t st,
    output dwrp_pkg::cmd_bus_t  c
);
    import dwrp_pkg::*;

    state_t state_reg, state_next;
    logic [AddrW-1:0] i_reg, i_next;
    logic [AddrW-1:0] w_reg, w_next;
    logic out_valid_reg, out_valid_next;
    logic res_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            i_reg <= '0;
            w_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            i_reg <= i_next;
            w_reg <= w_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;

    always_comb begin
        state_next = state_reg;
        i_next = i_reg;
        w_next = w_reg;
        c = '0;
        res_load = 1'b0;
        unique case (state_reg)
            // Fill the pool with ascending numbers, one entry a cycle.
            S_INIT: begin
                c.addr = i_reg;
                c.pool_wr = 1'b1;
                c.wsel = 2'd0;
                i_next = i_reg + 1'b1;
                if (i_reg == AddrW'(PoolSize - 1)) begin
                    i_next = '0;
                    if (st.cmd == CMD_RESET && out_valid_reg == 1'b0 &&
                        st.stack_count == '0 && st.found) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_IDLE;
                    end
                    c.clr_found = 1'b1;
                end
            end
            S_IDLE: begin
                if (in_valid && in_ready) begin
                    c.load_item = 1'b1;
                    c.clr_found = 1'b1;
                    i_next = '0;
                    w_next = '0;
                    state_next = S_PICK_RD;
                end
            end
            // Dispatch happens here, in the cycle after the beat is captured.
            S_PICK_RD: begin
                unique case (st.cmd)
                    CMD_PICK: begin
                        if (st.pool_count == '0 || st.stack_count >= AddrW'(PoolSize)) begin
                            c.res_kind = ST_EMPTY;
                            res_load = 1'b1;
                            state_next = S_DONE;
                        end else begin
                            c.mul_idx = 1'b1;
                            state_next = S_PICK_WAIT;
                        end
                    end
                    CMD_ADD: begin
                        if (st.number == 8'd0 || st.number > 8'(PoolSize)) begin
                            c.res_kind = ST_RANGE;
                            res_load = 1'b1;
                            state_next = S_DONE;
                        end else if (st.stack_count == '0) begin
                            state_next = S_SHIFT_RD;
                        end else begin
                            c.stack_rd = 1'b1;
                            c.addr = '0;
                            i_next = AddrW'(1);
                            state_next = S_SEARCH;
                        end
                    end
                    CMD_UNDO: begin
                        if (st.stack_count == '0 || st.pool_count >= AddrW'(PoolSize)) begin
                            c.res_kind = ST_RANGE;
                            res_load = 1'b1;
                            state_next = S_DONE;
                        end else begin
                            c.stack_rd = 1'b1;
                            c.addr = st.stack_count - 1'b1;
                            state_next = S_UNDO_WR;
                        end
                    end
                    CMD_RESET: begin
                        c.cnt_reset = 1'b1;
                        c.set_found = 1'b1;
                        i_next = '0;
                        state_next = S_UNDO_RD;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_UNDO_RD: begin
                // Reset refill: counts already restored.
                c.addr = i_reg;
                c.pool_wr = 1'b1;
                c.wsel = 2'd0;
                i_next = i_reg + 1'b1;
                if (i_reg == AddrW'(PoolSize - 1)) begin
                    i_next = '0;
                    res_load = 1'b1;
                    c.res_kind = ST_OK;
                    state_next = S_DONE;
                end
            end
            S_UNDO_WR: begin
                c.addr = st.pool_count;
                c.wsel = 2'd2;
                c.pool_wr = 1'b1;
                c.cnt_undo = 1'b1;
                state_next = S_PICK_LAST;
            end
            S_PICK_LAST: begin
                // Result after counters have settled.
                res_load = 1'b1;
                c.res_kind = ST_OK;
                c.res_drawn = (st.cmd == CMD_PICK);
                state_next = S_DONE;
            end
            S_PICK_WAIT: begin
                c.pool_rd = 1'b1;
                c.addr = st.pick_idx;
                state_next = S_PICK_WR;
                i_next = '0;
            end
            S_PICK_WR: begin
                if (i_reg == '0) begin
                    c.hold_pick = 1'b1;
                    c.stack_wr = 1'b1;
                    c.addr = st.stack_count;
                    c.wsel = 2'd1;
                    i_next = AddrW'(1);
                end else if (i_reg == AddrW'(1)) begin
                    // Fetch the last pool entry to fill the vacated slot.
                    c.pool_rd = 1'b1;
                    c.addr = st.pool_count - 1'b1;
                    i_next = AddrW'(2);
                end else begin
                    c.pool_wr = 1'b1;
                    c.addr = st.pick_idx;
                    c.wsel = 2'd1;
                    c.cnt_pick = 1'b1;
                    state_next = S_PICK_LAST;
                end
            end
            // Compare stack entries one a cycle against the number.
            S_SEARCH: begin
                if (st.stack_q == st.number[EntryW-1:0]) begin
                    c.res_kind = ST_DRAWN;
                    res_load = 1'b1;
                    state_next = S_DONE;
                end else if (i_reg >= st.stack_count) begin
                    if (st.stack_count >= AddrW'(PoolSize)) begin
                        c.res_kind = ST_RANGE;
                        res_load = 1'b1;
                        state_next = S_DONE;
                    end else begin
                        i_next = '0;
                        state_next = S_SHIFT_RD;
                    end
                end else begin
                    c.stack_rd = 1'b1;
                    c.addr = i_reg;
                    i_next = i_reg + 1'b1;
                end
            end
            // Compact the pool in place, dropping the added number, then push it onto the stack.
            S_SHIFT_RD: begin
                if (i_reg >= st.pool_count) begin
                    c.stack_wr = 1'b1;
                    c.addr = st.stack_count;
                    c.wsel = 2'd3;
                    c.cnt_add = 1'b1;
                    state_next = S_PICK_LAST;
                end else begin
                    c.pool_rd = 1'b1;
                    c.addr = i_reg;
                    i_next = i_reg + 1'b1;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                if (st.pool_q != st.number[EntryW-1:0]) begin
                    c.pool_wr = 1'b1;
                    c.addr = w_reg;
                    c.wsel = 2'd1;
                    w_next = w_reg + 1'b1;
                end
                state_next = S_SHIFT_RD;
            end
            S_DONE: begin
                if (!out_valid_reg) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        c.res_load = res_load;
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (res_load) out_valid_next = 1'b1;
        else if (out_valid_reg && out_ready) out_valid_next = 1'b0;
    end

endmodule

@@ design/draw_without_replacement_pool_core.sv @@
// Top level of the draw-without-replacement pool: controller plus datapath.
// The time from an accepted beat to a valid result depends on the command and is set by
// its memory sweeps; a command rejected at dispatch loads its result without a sweep.
// Throughput: one command at a time; the next beat is taken once the result is gone.
// Reset: aresetn (synchronous, active low) clears control, then the pool is filled;
// no beat is accepted while the fill runs.
module draw_without_replacement_pool_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // command[1:0], number[9:2], random_word[41:10]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // drawn_number[7:0], status[9:8],
                                   // remaining_count[16:10], drawn_count[23:17]
);
    import dwrp_pkg::*;

    cmd_bus_t  cbus;
    stat_bus_t sbus;

    dwrp_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .st(sbus), .c(cbus)
    );

    dwrp_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .item(s_tdata[41:0]), .c(cbus), .st(sbus), .result(m_tdata)
    );

`ifndef SYNTHESIS
    a_count_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (sbus.pool_count + sbus.stack_count) == 8'(PoolSize))
        else $error("pool and stack counts do not partition the numbers");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("beat accepted while a result is pending");
    a_empty_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[9:8] == ST_EMPTY) |-> m_tdata[7:0] == EmptyMark)
        else $error("empty status without empty mark");
`endif

endmodule
